@@ rtl/sha_pkg.sv @@
// SHA-256 package: shared types, round constants and a helper function.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } sha_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } sha_state_t;

    localparam logic [31:0] INIT_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/sha_front.sv @@
// Input front end: two-entry item queue between the input channel and the engine.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  sha_item_t in_item,
    output logic      q_valid,
    input  logic      q_take,
    output sha_item_t q_item
);

    sha_item_t  slot_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    // Drop idle items at the door; they never reach the engine.
    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall && (in_item.present || in_item.last);
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_item   = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/sha_engine.sv @@
// Back end: byte packing, padding, 64-round compression and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_engine
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_take,
    input  sha_item_t   q_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);

    sha_state_t  state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] blk_reg  [16];
    logic [31:0] win_reg  [16];
    logic [31:0] wk_reg   [8];
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  emit_reg;
    logic        final_reg;    // compression is the last of the message
    logic        second_reg;   // padding needs a second block
    logic        pad_pend_reg; // final byte filled the block, pad after it

    logic [5:0]  pos;
    logic [3:0]  widx;
    logic [4:0]  sh;
    logic [31:0] placed;
    logic [31:0] wt, w2, w7, w15, w16, wnew;
    logic [31:0] t1, t2, ch, mj, bs0, bs1;
    logic        accept_byte, start_comp;

    assign pos  = bits_reg[8:3];
    assign widx = pos[5:2];
    assign sh   = {~pos[1:0], 3'b000};

    // Hold the queue while the engine is busy.
    assign q_take = q_valid && (state_reg == ST_IDLE);
    assign accept_byte = q_take && q_item.present;

    always_comb
    begin
        logic [7:0] b;
        b = accept_byte ? q_item.data : PAD_BYTE;
        placed = ((pos[1:0] == 2'b00) ? 32'd0 : blk_reg[widx]) | ({24'd0, b} << sh);
    end

    // Message schedule, computed in the window one slot per round.
    assign w2  = win_reg[4'(rnd_reg[3:0] - 4'd2)];
    assign w7  = win_reg[4'(rnd_reg[3:0] - 4'd7)];
    assign w15 = win_reg[4'(rnd_reg[3:0] - 4'd15)];
    assign w16 = win_reg[rnd_reg[3:0]];
    assign wnew = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w7
                + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w16;
    assign wt  = (rnd_reg < 6'd16) ? w16 : wnew;

    assign bs1 = rotr(wk_reg[4], 6) ^ rotr(wk_reg[4], 11) ^ rotr(wk_reg[4], 25);
    assign bs0 = rotr(wk_reg[0], 2) ^ rotr(wk_reg[0], 13) ^ rotr(wk_reg[0], 22);
    assign ch  = (wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]);
    assign mj  = (wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2])
               ^ (wk_reg[1] & wk_reg[2]);
    assign t1  = wk_reg[7] + bs1 + ch + ROUND_CONST[rnd_reg] + wt;
    assign t2  = bs0 + mj;

    assign start_comp = accept_byte && (pos == 6'd63);

    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = hash_reg[emit_reg];
    assign word_number = emit_reg;
    assign last_word   = (emit_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_comp)
                begin
                    state_next = ST_ROUND;
                end
                else if (q_take && q_item.last)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:   state_next = ST_ROUND;
            ST_ROUND: state_next = (rnd_reg == 6'd63) ? ST_FOLD : ST_ROUND;
            ST_FOLD:
            begin
                if (second_reg)
                begin
                    state_next = ST_ROUND;
                end
                else if (pad_pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (final_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall && emit_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bits_reg     <= 64'd0;
            rnd_reg      <= 6'd0;
            emit_reg     <= 3'd0;
            final_reg    <= 1'b0;
            second_reg   <= 1'b0;
            pad_pend_reg <= 1'b0;
            hash_reg     <= INIT_WORDS;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_byte)
                    begin
                        bits_reg <= bits_reg + 64'd8;
                    end
                    // A final item whose byte fills the block pads afterwards.
                    final_reg    <= q_take && q_item.last;
                    pad_pend_reg <= start_comp && q_item.last;
                    rnd_reg      <= 6'd0;
                end
                ST_PAD:
                begin
                    second_reg   <= (pos >= 6'd56);
                    final_reg    <= 1'b1;
                    pad_pend_reg <= 1'b0;
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + wk_reg[i];
                    end
                    rnd_reg    <= 6'd0;
                    second_reg <= 1'b0;
                    emit_reg   <= 3'd0;
                    if (!second_reg && !final_reg)
                    begin
                        final_reg <= 1'b0;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            hash_reg  <= INIT_WORDS;
                            bits_reg  <= 64'd0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_byte)
                begin
                    blk_reg[widx] <= placed;
                end
                if (start_comp)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        win_reg[i] <= blk_reg[i];
                    end
                    win_reg[15] <= placed;
                    wk_reg <= hash_reg;
                end
            end
            ST_PAD:
            begin
                // Place the pad byte, clear the tail, then load the window.
                for (int i = 0; i < 16; i++)
                begin
                    logic [31:0] v;
                    if (4'(i) == widx)
                    begin
                        v = placed;
                    end
                    else if (4'(i) > widx)
                    begin
                        v = 32'd0;
                    end
                    else
                    begin
                        v = blk_reg[i];
                    end
                    if (pos < 6'd56 && i == 14)
                    begin
                        v = bits_reg[63:32];
                    end
                    if (pos < 6'd56 && i == 15)
                    begin
                        v = bits_reg[31:0];
                    end
                    win_reg[i] <= v;
                    if (i == 14)
                    begin
                        blk_reg[i] <= bits_reg[63:32];
                    end
                    else if (i == 15)
                    begin
                        blk_reg[i] <= bits_reg[31:0];
                    end
                    else
                    begin
                        blk_reg[i] <= 32'd0;
                    end
                end
                wk_reg <= hash_reg;
            end
            ST_ROUND:
            begin
                win_reg[rnd_reg[3:0]] <= wt;
                wk_reg[7] <= wk_reg[6];
                wk_reg[6] <= wk_reg[5];
                wk_reg[5] <= wk_reg[4];
                wk_reg[4] <= wk_reg[3] + t1;
                wk_reg[3] <= wk_reg[2];
                wk_reg[2] <= wk_reg[1];
                wk_reg[1] <= wk_reg[0];
                wk_reg[0] <= t1 + t2;
            end
            ST_FOLD:
            begin
                // Second padding block: zeros then the length.
                for (int i = 0; i < 16; i++)
                begin
                    win_reg[i] <= blk_reg[i];
                end
                for (int i = 0; i < 8; i++)
                begin
                    wk_reg[i] <= hash_reg[i] + wk_reg[i];
                end
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/sha256_message_digest_core.sv @@
// Top level of the SHA-256 byte-stream digest core.
// Depends on sha_pkg, sha_front and sha_engine.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per handshake with
//   message_byte, byte_present and end_of_message. An item with neither
//   flag set is ignored. The final item may carry no byte.
//   Output channel (out_valid / out_stall): eight items per message,
//   digest_word with word_number 0..7, last_word set on word 7.
// Operation:
//   A byte that does not complete a block is taken while the engine is idle.
//   A byte that completes a block holds the engine for 64 rounds in the
//   single round unit plus a fold step. The final item adds a pad step
//   and one or two compressions, then the eight output words.
//   A two-entry queue keeps accepting items while the engine is busy, until it is full.
// Reset:
//   rst_n clears the queue, restores the initial hash values and zeroes
//   the bit count.
// Stall:
//   While out_stall is high the current digest word holds steady and the
//   engine waits; the queue fills and then raises in_stall.
`timescale 1ns / 1ps
module sha256_message_digest_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  message_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);

    sha_item_t in_item, q_item;
    logic      q_valid, q_take;

    assign in_item = '{data: message_byte, present: byte_present, last: end_of_message};

    sha_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    sha_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_number (word_number),
        .last_word   (last_word)
    );

endmodule
